// ===== rtl/brpt_pkg.sv =====
package brpt_pkg;

   // reply qualification
   localparam logic [7:0] RPT_ID_BATTERY = 8'h08;
   localparam logic [6:0] MIN_REPLY_LEN  = 7'd10;
   localparam logic [7:0] FULL_PERCENT   = 8'd100;
   localparam logic [7:0] CHARGE_ON      = 8'h01;

   // failure limit register
   localparam int unsigned LIMIT_WIDTH = 4;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_AT_RESET = 4'd3;

   // poll outcome codes
   typedef enum logic {
      ACT_FAIL  = 1'b0,
      ACT_REPLY = 1'b1
   } action_type;

   // reported battery status
   typedef enum logic [1:0] {
      ST_UNKNOWN     = 2'd0,
      ST_CHARGING    = 2'd1,
      ST_FULL        = 2'd2,
      ST_DISCHARGING = 2'd3
   } status_type;

   // one poll outcome
   typedef struct packed {
      logic        action;
      logic [7:0]  report_id;
      logic [6:0]  reply_size;
      logic [7:0]  percent_byte;
      logic [7:0]  charge_byte;
      logic [15:0] reply_mv;
   } req_item_type;

   // one tracker result
   typedef struct packed {
      logic        changed;
      logic        present;
      logic [1:0]  status;
      logic [6:0]  capacity;
      logic        capacity_valid;
      logic [15:0] batt_mv;
      logic        voltage_valid;
   } rsp_item_type;

endpackage

// ===== rtl/brpt_req_if.sv =====
interface brpt_req_if;
   logic                  valid;
   logic                  ready;
   brpt_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/brpt_rsp_if.sv =====
interface brpt_rsp_if;
   logic                  valid;
   logic                  ready;
   brpt_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/brpt_in_stage.sv =====
module brpt_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   brpt_req_if.sink               req_ch,
   input  logic                   take,
   output logic                   item_valid,
   output brpt_pkg::req_item_type item
);

   logic                   valid_ff, valid_in;
   brpt_pkg::req_item_type item_ff, item_in;
   logic                   accept;

   // slot is free when empty or being drained this cycle
   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_ch.item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/brpt_update.sv =====
module brpt_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [brpt_pkg::LIMIT_WIDTH-1:0]    csr_wdata,
   input  logic                                item_valid,
   input  brpt_pkg::req_item_type              item,
   output logic                                take,
   brpt_rsp_if.source                          rsp_ch
);

   logic [brpt_pkg::LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [brpt_pkg::LIMIT_WIDTH-1:0] count_ff, count_in;
   logic [6:0]                       cap_ff, cap_in;
   logic [15:0]                      volt_ff, volt_in;
   logic                             chg_ff, chg_in;
   logic                             pres_ff, pres_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   brpt_pkg::rsp_item_type           rsp_ff, rsp_in;

   logic                             good_reply;
   logic [6:0]                       new_cap;
   logic                             new_chg;
   logic                             changed;
   logic                             vvalid;
   brpt_pkg::status_type             status;

   // move an item forward when the result slot is free or draining
   assign take = item_valid && (!rsp_valid_ff || rsp_ch.ready);

   // qualify the reply and decode its bytes
   always_comb begin
      good_reply = (item.action == brpt_pkg::ACT_REPLY)
                   && (item.report_id == brpt_pkg::RPT_ID_BATTERY)
                   && (item.reply_size >= brpt_pkg::MIN_REPLY_LEN);
      new_cap    = (item.percent_byte > brpt_pkg::FULL_PERCENT)
                   ? brpt_pkg::FULL_PERCENT[6:0] : item.percent_byte[6:0];
      new_chg    = (item.charge_byte == brpt_pkg::CHARGE_ON);
   end

   // tracker state update
   always_comb begin
      limit_in = limit_ff;
      count_in = count_ff;
      cap_in   = cap_ff;
      volt_in  = volt_ff;
      chg_in   = chg_ff;
      pres_in  = pres_ff;
      changed  = 1'b0;
      if (csr_we) begin
         limit_in = csr_wdata;
      end
      if (take) begin
         if (good_reply) begin
            changed  = !pres_ff || (cap_ff != new_cap) || (chg_ff != new_chg)
                       || (volt_ff != item.reply_mv);
            cap_in   = new_cap;
            chg_in   = new_chg;
            volt_in  = item.reply_mv;
            pres_in  = 1'b1;
            count_in = '0;
         end else begin
            // saturating failure count; absent once it reaches the limit
            if (count_ff < limit_ff) begin
               count_in = count_ff + 1'b1;
            end
            if ((count_in >= limit_ff) && pres_ff) begin
               pres_in = 1'b0;
               changed = 1'b1;
            end
         end
      end
   end

   // result fields from the updated state
   always_comb begin
      priority if (!pres_in) begin
         status = brpt_pkg::ST_UNKNOWN;
      end else if (chg_in) begin
         status = brpt_pkg::ST_CHARGING;
      end else if ({1'b0, cap_in} >= brpt_pkg::FULL_PERCENT) begin
         status = brpt_pkg::ST_FULL;
      end else begin
         status = brpt_pkg::ST_DISCHARGING;
      end
      vvalid                = pres_in && (volt_in != 16'd0);
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff;
      if (take) begin
         rsp_valid_in          = 1'b1;
         rsp_in.changed        = changed;
         rsp_in.present        = pres_in;
         rsp_in.status         = status;
         rsp_in.capacity       = pres_in ? cap_in : 7'd0;
         rsp_in.capacity_valid = pres_in;
         rsp_in.batt_mv        = vvalid ? volt_in : 16'd0;
         rsp_in.voltage_valid  = vvalid;
      end else if (rsp_ch.ready) begin
         rsp_valid_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= brpt_pkg::LIMIT_AT_RESET;
         count_ff     <= '0;
         cap_ff       <= '0;
         volt_ff      <= '0;
         chg_ff       <= 1'b0;
         pres_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         volt_ff      <= volt_in;
         chg_ff       <= chg_in;
         pres_ff      <= pres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.item  = rsp_ff;

endmodule

// ===== rtl/battery_reply_presence_tracker_unit.sv =====
// Battery reply presence tracker.
// req_ch carries one poll outcome per item (failure, or a reply report with
// id, length, percent, charge and voltage bytes); rsp_ch returns exactly one
// result per item: changed, present, status, capacity and voltage with their
// valid marks. Both channels use valid/ready; an item moves when both are high.
// csr_we/csr_wdata write the failure limit; write it only while idle.
// The result passes through the input register, then the result register.
// Throughput: one item per cycle while rsp_ch does not stall, set by the
// combinational state update between the two registers.
// When rsp_ch stalls, the result register holds; one more item waits in the
// input register, after which req_ch.ready drops until the result is taken.
// Synchronous reset clears both registers' valid flags and the tracker state:
// device absent, stored readings and failure count zero, failure limit 3.
module battery_reply_presence_tracker_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [brpt_pkg::LIMIT_WIDTH-1:0] csr_wdata,
   brpt_req_if.sink                         req_ch,
   brpt_rsp_if.source                       rsp_ch
);

   logic                   item_valid;
   logic                   take;
   brpt_pkg::req_item_type item;

   // input register
   brpt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // state update and result register
   brpt_update u_update (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_STALL_CYCLES = 300;
   localparam int PHASE_ITEMS       = 110;

   // predicts tracker results and checks them in order
   class presence_scoreboard;
      logic [brpt_pkg::LIMIT_WIDTH-1:0] limit;
      logic [6:0]                       cap_q;
      logic [15:0]                      volt_q;
      logic                             charging_q;
      logic                             present_q;
      logic [brpt_pkg::LIMIT_WIDTH-1:0] fail_cnt;
      brpt_pkg::rsp_item_type           expected_q[$];
      int                               errors;

      function new();
         limit      = brpt_pkg::LIMIT_AT_RESET;
         cap_q      = '0;
         volt_q     = '0;
         charging_q = 1'b0;
         present_q  = 1'b0;
         fail_cnt   = '0;
         errors     = 0;
      endfunction

      function void set_limit(logic [brpt_pkg::LIMIT_WIDTH-1:0] v);
         limit = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // update tracker state for one accepted poll outcome
      function void note_poll(brpt_pkg::req_item_type p);
         brpt_pkg::rsp_item_type r;
         logic [6:0]             cap;
         logic                   chg;
         logic                   reply_ok;
         r = '0;
         reply_ok = (p.action == brpt_pkg::ACT_REPLY) &&
                    (p.report_id == brpt_pkg::RPT_ID_BATTERY) &&
                    (p.reply_size >= brpt_pkg::MIN_REPLY_LEN);
         if (reply_ok) begin
            cap = (p.percent_byte > brpt_pkg::FULL_PERCENT) ?
                  7'(brpt_pkg::FULL_PERCENT) : p.percent_byte[6:0];
            chg = (p.charge_byte == brpt_pkg::CHARGE_ON);
            r.changed = !present_q || (cap_q != cap) || (charging_q != chg) ||
                        (volt_q != p.reply_mv);
            cap_q      = cap;
            charging_q = chg;
            volt_q     = p.reply_mv;
            present_q  = 1'b1;
            fail_cnt   = '0;
         end else begin
            // count saturates at the limit
            if (fail_cnt < limit) fail_cnt = fail_cnt + 1'b1;
            if (fail_cnt >= limit && present_q) begin
               present_q = 1'b0;
               r.changed = 1'b1;
            end
         end
         if (!present_q) r.status = brpt_pkg::ST_UNKNOWN;
         else if (charging_q) r.status = brpt_pkg::ST_CHARGING;
         else if (cap_q >= 7'(brpt_pkg::FULL_PERCENT)) r.status = brpt_pkg::ST_FULL;
         else r.status = brpt_pkg::ST_DISCHARGING;
         r.present        = present_q;
         r.capacity       = present_q ? cap_q : 7'd0;
         r.capacity_valid = present_q;
         r.voltage_valid  = present_q && (volt_q != 16'd0);
         r.batt_mv        = r.voltage_valid ? volt_q : 16'd0;
         expected_q.push_back(r);
      endfunction

      function void check_field(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(brpt_pkg::rsp_item_type a);
         brpt_pkg::rsp_item_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: expected none actual %h", $time, a);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         check_field("changed", e.changed, a.changed);
         check_field("present", e.present, a.present);
         check_field("status", e.status, a.status);
         check_field("capacity", e.capacity, a.capacity);
         check_field("capacity_valid", e.capacity_valid, a.capacity_valid);
         check_field("batt_mv", e.batt_mv, a.batt_mv);
         check_field("voltage_valid", e.voltage_valid, a.voltage_valid);
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [brpt_pkg::LIMIT_WIDTH-1:0] csr_wdata;

   brpt_req_if req_ch();
   brpt_rsp_if rsp_ch();

   battery_reply_presence_tracker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   presence_scoreboard tracker_sb = new();

   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   bit                     long_stall_go = 1'b0;
   brpt_pkg::req_item_type last_reply;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // accepted items on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) tracker_sb.note_poll(req_ch.item);
         if (rsp_ch.valid && rsp_ch.ready) tracker_sb.check_result(rsp_ch.item);
      end
   end

   // result receiver: random stalls plus one long hold-off
   initial begin : receiver
      bit stall_done;
      stall_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_go && !stall_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(negedge clock);
            stall_done = 1'b1;
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one poll outcome, return at the falling edge after acceptance
   task automatic send_poll(brpt_pkg::req_item_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.item  <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(logic act, logic [7:0] rid, logic [6:0] len,
                              logic [7:0] pct, logic [7:0] chg, logic [15:0] mv);
      brpt_pkg::req_item_type p;
      p.action       = act;
      p.report_id    = rid;
      p.reply_size   = len;
      p.percent_byte = pct;
      p.charge_byte  = chg;
      p.reply_mv     = mv;
      send_poll(p);
   endtask

   task automatic send_failure();
      send_fields(brpt_pkg::ACT_FAIL, 8'($urandom), 7'($urandom_range(64)), 8'($urandom),
                  8'($urandom), 16'($urandom));
   endtask

   // wait until every result is back, then write the limit
   task automatic write_limit(logic [brpt_pkg::LIMIT_WIDTH-1:0] v);
      req_ch.valid <= 1'b0;
      while (tracker_sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      tracker_sb.set_limit(v);
      @(negedge clock);
   endtask

   // mostly well-formed replies, some malformed ones and plain failures
   function automatic brpt_pkg::req_item_type random_poll();
      brpt_pkg::req_item_type p;
      int                     pick;
      pick = $urandom_range(99);
      p.action       = 1'($urandom_range(1));
      p.report_id    = 8'($urandom);
      p.reply_size   = 7'($urandom_range(64));
      p.percent_byte = 8'($urandom);
      p.charge_byte  = 8'($urandom);
      p.reply_mv     = 16'($urandom);
      if (pick < 55) begin
         p.action     = brpt_pkg::ACT_REPLY;
         p.report_id  = brpt_pkg::RPT_ID_BATTERY;
         p.reply_size = ($urandom_range(3) == 0) ? brpt_pkg::MIN_REPLY_LEN
                                                 : 7'($urandom_range(64, 10));
         case ($urandom_range(3))
            0: p.percent_byte = 8'($urandom);
            1: p.percent_byte = brpt_pkg::FULL_PERCENT;
            default: p.percent_byte = 8'($urandom_range(100));
         endcase
         if ($urandom_range(1) == 0) p.charge_byte = brpt_pkg::CHARGE_ON;
         if ($urandom_range(7) == 0) p.reply_mv = 16'd0;
         // repeat the last reading so that changed stays low
         if ($urandom_range(3) == 0) begin
            p.percent_byte = last_reply.percent_byte;
            p.charge_byte  = last_reply.charge_byte;
            p.reply_mv     = last_reply.reply_mv;
         end
         last_reply = p;
      end else if (pick < 70) begin
         p.action = brpt_pkg::ACT_REPLY;
         if ($urandom_range(1) == 0) begin
            p.report_id  = brpt_pkg::RPT_ID_BATTERY;
            p.reply_size = 7'($urandom_range(9));
         end else if (p.report_id == brpt_pkg::RPT_ID_BATTERY) begin
            p.report_id = 8'h09;
         end
      end else begin
         p.action = brpt_pkg::ACT_FAIL;
      end
      return p;
   endfunction

   // set idle rates from the item count
   task automatic set_idle_mode(int n);
      if (n < 260) begin
         send_idle_pct = 30;
         recv_idle_pct = 80;
      end else if (n < 520) begin
         send_idle_pct = 80;
         recv_idle_pct = 30;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // main stimulus
   initial begin : stimulus
      logic [brpt_pkg::LIMIT_WIDTH-1:0] limits[7];
      int                               n;
      int                               burst;
      n = 0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.item  = '0;
      last_reply   = '0;
      limits = '{4'd1, 4'd15, 4'd0, 4'd3, 4'($urandom_range(15, 1)), 4'd15, 4'd1};
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset limit, edges of each field
      set_idle_mode(0);
      send_fields(brpt_pkg::ACT_FAIL, 8'h00, 7'd0, 8'h00, 8'h00, 16'h0000); // already absent
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, brpt_pkg::MIN_REPLY_LEN,
                  8'd0, 8'd0, 16'd0);                                      // zero voltage
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, brpt_pkg::MIN_REPLY_LEN,
                  8'd0, 8'd0, 16'd0);                                      // no change
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd64,
                  brpt_pkg::FULL_PERCENT, 8'd0, 16'd3700);
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd64, 8'hFF,
                  brpt_pkg::CHARGE_ON, 16'hFFFF);
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd33, 8'd101, 8'd2, 16'd1);
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd9, 8'd50,
                  brpt_pkg::CHARGE_ON, 16'd4000);                          // short
      send_fields(brpt_pkg::ACT_REPLY, 8'h09, 7'd64, 8'd50,
                  brpt_pkg::CHARGE_ON, 16'd4000);                          // wrong id
      send_fields(brpt_pkg::ACT_FAIL, brpt_pkg::RPT_ID_BATTERY, 7'd64, 8'hFF, 8'hFF,
                  16'hFFFF);                                               // goes absent
      send_fields(brpt_pkg::ACT_FAIL, 8'hFF, 7'd64, 8'hFF, 8'hFF, 16'hFFFF);
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd10, 8'd99, 8'hFF, 16'd4000);
      send_fields(brpt_pkg::ACT_REPLY, 8'hFF, 7'd64, 8'hFF, 8'hFF, 16'hFFFF);
      send_fields(brpt_pkg::ACT_REPLY, 8'h00, 7'd0, 8'h00, 8'h00, 16'h0000);
      send_fields(brpt_pkg::ACT_REPLY, 8'hF7, 7'd64, 8'd100, brpt_pkg::CHARGE_ON, 16'h8000);
      send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd63, 8'd100, 8'hFE,
                  16'h7FFF);
      send_fields(brpt_pkg::ACT_FAIL, 8'h00, 7'd0, 8'h00, 8'h00, 16'h0000);
      send_fields(brpt_pkg::ACT_FAIL, 8'h00, 7'd0, 8'h00, 8'h00, 16'h0000);
      send_fields(brpt_pkg::ACT_FAIL, 8'h00, 7'd0, 8'h00, 8'h00, 16'h0000);

      // random phases, one limit setting each
      foreach (limits[i]) begin
         write_limit(limits[i]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            set_idle_mode(n);
            if (n == 600) long_stall_go = 1'b1;
            if ($urandom_range(19) == 0) begin
               // failure run of up to 17 items, which can reach any limit
               burst = $urandom_range(17, 1);
               repeat (burst) send_failure();
            end else begin
               send_poll(random_poll());
            end
            n++;
         end
         // leave the count high before the next limit write
         send_fields(brpt_pkg::ACT_REPLY, brpt_pkg::RPT_ID_BATTERY, 7'd20, 8'd42, 8'd0,
                     16'd3900);
         repeat (6) send_failure();
      end

      // drain
      req_ch.valid <= 1'b0;
      while (tracker_sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (tracker_sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
